[rtl/sct_pkg.sv]
package sct_pkg;

    // Default widths of the position and length counters.
    localparam int LINE_BITS_DEF = 24;
    localparam int COL_BITS_DEF  = 16;
    localparam int LEN_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int KIND_BITS = 6;
    localparam int VAL_BITS  = 63;

    // Depth of the token queue between scanner and output stage.
    localparam int Q_DEPTH = 4;

    // Token kinds.
    localparam logic [KIND_BITS-1:0] K_EOF     = 6'd0;
    localparam logic [KIND_BITS-1:0] K_IDENT   = 6'd1;
    localparam logic [KIND_BITS-1:0] K_INTLIT  = 6'd2;
    localparam logic [KIND_BITS-1:0] K_KW_BASE = 6'd3;
    localparam logic [KIND_BITS-1:0] K_LPAREN  = 6'd20;
    localparam logic [KIND_BITS-1:0] K_RPAREN  = 6'd21;
    localparam logic [KIND_BITS-1:0] K_LBRACK  = 6'd22;
    localparam logic [KIND_BITS-1:0] K_RBRACK  = 6'd23;
    localparam logic [KIND_BITS-1:0] K_LBRACE  = 6'd24;
    localparam logic [KIND_BITS-1:0] K_RBRACE  = 6'd25;
    localparam logic [KIND_BITS-1:0] K_COMMA   = 6'd26;
    localparam logic [KIND_BITS-1:0] K_COLON   = 6'd27;
    localparam logic [KIND_BITS-1:0] K_SEMI    = 6'd28;
    localparam logic [KIND_BITS-1:0] K_PLUSEQ  = 6'd29;
    localparam logic [KIND_BITS-1:0] K_PLUS    = 6'd30;
    localparam logic [KIND_BITS-1:0] K_ARROW   = 6'd31;
    localparam logic [KIND_BITS-1:0] K_MINUSEQ = 6'd32;
    localparam logic [KIND_BITS-1:0] K_MINUS   = 6'd33;
    localparam logic [KIND_BITS-1:0] K_STAREQ  = 6'd34;
    localparam logic [KIND_BITS-1:0] K_STAR    = 6'd35;
    localparam logic [KIND_BITS-1:0] K_SLASHEQ = 6'd36;
    localparam logic [KIND_BITS-1:0] K_SLASH   = 6'd37;
    localparam logic [KIND_BITS-1:0] K_PCTEQ   = 6'd38;
    localparam logic [KIND_BITS-1:0] K_PCT     = 6'd39;
    localparam logic [KIND_BITS-1:0] K_NE      = 6'd40;
    localparam logic [KIND_BITS-1:0] K_NOT     = 6'd41;
    localparam logic [KIND_BITS-1:0] K_ANDAND  = 6'd42;
    localparam logic [KIND_BITS-1:0] K_OROR    = 6'd43;
    localparam logic [KIND_BITS-1:0] K_EQEQ    = 6'd44;
    localparam logic [KIND_BITS-1:0] K_ASSIGN  = 6'd45;
    localparam logic [KIND_BITS-1:0] K_LE      = 6'd46;
    localparam logic [KIND_BITS-1:0] K_LT      = 6'd47;
    localparam logic [KIND_BITS-1:0] K_GE      = 6'd48;
    localparam logic [KIND_BITS-1:0] K_GT      = 6'd49;

    // Keyword table: first bytes packed little-endian, and length.
    localparam int NUM_KW = 17;
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'h74656c,           // let
        64'h6e66,             // fn
        64'h6669,             // if
        64'h65736c65,         // else
        64'h656c696877,       // while
        64'h6e7275746572,     // return
        64'h7265666564,       // defer
        64'h6b61657262,       // break
        64'h65756e69746e6f63, // continue
        64'h65757274,         // true
        64'h65736c6166,       // false
        64'h323369,           // i32
        64'h343669,           // i64
        64'h6c6f6f62,         // bool
        64'h64696f76,         // void
        64'h727470,           // ptr
        64'h657571696e75      // unique
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd2, 4'd2, 4'd4, 4'd5, 4'd6, 4'd5, 4'd5, 4'd8,
        4'd4, 4'd5, 4'd3, 4'd3, 4'd4, 4'd4, 4'd3, 4'd6
    };

    // Valid bits of the two token slots that the scanner hands over per beat.
    typedef struct packed {
        logic a_v;
        logic b_v;
    } push_ctl_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    // Characters that may open a two-character operator.
    function automatic logic is_hold(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "!"
            || c == "&" || c == "|" || c == "=" || c == "<" || c == ">";
    endfunction

    // Kind of a two-character operator, or the end-of-file code when none.
    function automatic logic [KIND_BITS-1:0] pair_kind(input logic [7:0] h,
                                                       input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        k = K_EOF;
        case (h)
            "+": if (c == "=") k = K_PLUSEQ;
            "-": if (c == ">") k = K_ARROW; else if (c == "=") k = K_MINUSEQ;
            "*": if (c == "=") k = K_STAREQ;
            "/": if (c == "=") k = K_SLASHEQ;
            "%": if (c == "=") k = K_PCTEQ;
            "!": if (c == "=") k = K_NE;
            "&": if (c == "&") k = K_ANDAND;
            "|": if (c == "|") k = K_OROR;
            "=": if (c == "=") k = K_EQEQ;
            "<": if (c == "=") k = K_LE;
            ">": if (c == "=") k = K_GE;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    // Kind of a held character that ends up standing alone.
    function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] h);
        logic [KIND_BITS-1:0] k;
        case (h)
            "+": k = K_PLUS;
            "-": k = K_MINUS;
            "*": k = K_STAR;
            "/": k = K_SLASH;
            "%": k = K_PCT;
            "!": k = K_NOT;
            "=": k = K_ASSIGN;
            "<": k = K_LT;
            ">": k = K_GT;
            default: k = K_SEMI;
        endcase
        return k;
    endfunction

    // Kind of a one-character punctuator that is emitted at once.
    function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        case (c)
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "[": k = K_LBRACK;
            "]": k = K_RBRACK;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            ",": k = K_COMMA;
            ":": k = K_COLON;
            default: k = K_SEMI;
        endcase
        return k;
    endfunction

    // Keyword lookup; short is high when the word has at most eight bytes.
    function automatic logic [KIND_BITS-1:0] word_kind(input logic [63:0] prefix,
                                                       input logic [3:0] len,
                                                       input logic short);
        logic [KIND_BITS-1:0] k;
        k = K_IDENT;
        for (int i = 0; i < NUM_KW; i++) begin
            if (short && len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
                k = K_KW_BASE + KIND_BITS'(i);
            end
        end
        return k;
    endfunction

endpackage

[rtl/source_code_tokenizer.sv]
// Streaming tokenizer: one source byte (ch, or is_end) enters per beat and one token
// leaves per beat. The scanner takes a byte every cycle while in_stall is low; it
// classifies the byte and updates its state in that cycle, and hands the zero, one or
// two tokens the byte causes to a four-entry queue. A registered output stage drains
// that queue one token a cycle while out_stall is low, so two tokens from one byte leave
// one after the other, and the input stalls only when the queue has fewer than two free
// entries. A token passes through the queue, then the output register. End of input or
// a zero byte emits an eof token and returns the block to line 1, column 1.
module source_code_tokenizer #(
    parameter int LINE_BITS = sct_pkg::LINE_BITS_DEF,
    parameter int COL_BITS  = sct_pkg::COL_BITS_DEF,
    parameter int LEN_BITS  = sct_pkg::LEN_BITS_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    ch,
    input  logic                          is_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sct_pkg::KIND_BITS-1:0] kind,
    output logic [sct_pkg::VAL_BITS-1:0]  value,
    output logic [LEN_BITS-1:0]           length,
    output logic [LINE_BITS-1:0]          line,
    output logic [COL_BITS-1:0]           column,
    output logic                          overflow,
    output logic                          last
);

    localparam int TOK_W = sct_pkg::KIND_BITS + sct_pkg::VAL_BITS + LEN_BITS
                         + LINE_BITS + COL_BITS + 2;

    sct_pkg::push_ctl_t push;
    logic [TOK_W-1:0]   tok_a;
    logic [TOK_W-1:0]   tok_b;
    logic               q_full;

    // Byte scanner.
    sct_front #(
        .LINE_BITS (LINE_BITS),
        .COL_BITS  (COL_BITS),
        .LEN_BITS  (LEN_BITS),
        .TOK_W     (TOK_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ch       (ch),
        .is_end   (is_end),
        .q_full   (q_full),
        .push     (push),
        .tok_a    (tok_a),
        .tok_b    (tok_b)
    );

    // Token queue and output stage.
    sct_back #(
        .LINE_BITS (LINE_BITS),
        .COL_BITS  (COL_BITS),
        .LEN_BITS  (LEN_BITS),
        .TOK_W     (TOK_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .tok_a     (tok_a),
        .tok_b     (tok_b),
        .q_full    (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .value     (value),
        .length    (length),
        .line      (line),
        .column    (column),
        .overflow  (overflow),
        .last      (last)
    );

endmodule

[rtl/sct_front.sv]
module sct_front #(
    parameter int LINE_BITS = sct_pkg::LINE_BITS_DEF,
    parameter int COL_BITS  = sct_pkg::COL_BITS_DEF,
    parameter int LEN_BITS  = sct_pkg::LEN_BITS_DEF,
    parameter int TOK_W     = sct_pkg::KIND_BITS + sct_pkg::VAL_BITS + LEN_BITS
                              + LINE_BITS + COL_BITS + 2
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         ch,
    input  logic               is_end,
    input  logic               q_full,
    output sct_pkg::push_ctl_t push,
    output logic [TOK_W-1:0]   tok_a,
    output logic [TOK_W-1:0]   tok_b
);

    typedef struct packed {
        logic [sct_pkg::KIND_BITS-1:0] kind;
        logic [sct_pkg::VAL_BITS-1:0]  value;
        logic [LEN_BITS-1:0]           len;
        logic [LINE_BITS-1:0]          line;
        logic [COL_BITS-1:0]           col;
        logic                          ovf;
        logic                          last;
    } tok_t;

    typedef enum logic [6:0] {
        M_IDLE  = 7'b0000001,
        M_WORD  = 7'b0000010,
        M_NUM   = 7'b0000100,
        M_HELD  = 7'b0001000,
        M_LCOM  = 7'b0010000,
        M_BCOM  = 7'b0100000,
        M_BSTAR = 7'b1000000
    } mode_t;

    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
    localparam logic [COL_BITS-1:0]  COL_MAX  = '1;
    localparam logic [LEN_BITS-1:0]  LEN_MAX  = '1;
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [COL_BITS-1:0]  COL_ONE  = COL_BITS'(1);
    localparam logic [LEN_BITS-1:0]  LEN_ONE  = LEN_BITS'(1);
    localparam logic [LEN_BITS-1:0]  LEN_TWO  = LEN_BITS'(2);
    localparam logic [LEN_BITS-1:0]  LEN_EIGHT = LEN_BITS'(8);
    localparam logic [sct_pkg::VAL_BITS-1:0] VAL_MAX = '1;

    mode_t                        mode_reg, mode_next;
    logic [7:0]                   held_reg, held_next;
    logic [63:0]                  prefix_reg, prefix_next;
    logic [LEN_BITS-1:0]          tlen_reg, tlen_next;
    logic [sct_pkg::VAL_BITS-1:0] nval_reg, nval_next;
    logic                         novf_reg, novf_next;
    logic [LINE_BITS-1:0]         line_reg, line_next;
    logic [COL_BITS-1:0]          col_reg, col_next;
    logic [LINE_BITS-1:0]         sline_reg, sline_next;
    logic [COL_BITS-1:0]          scol_reg, scol_next;

    logic                         fire;
    logic                         end_in;
    logic                         word_char;
    logic                         do_scan;
    logic                         a_v, b_v;
    tok_t                         a_tok, b_tok;
    logic [sct_pkg::VAL_BITS+3:0] val_x10;
    logic [sct_pkg::KIND_BITS-1:0] held_pair;
    logic [sct_pkg::KIND_BITS-1:0] kw;
    logic                         tlen_short;

    // Build one token; the flag also marks a start position at its limit.
    function automatic tok_t mk_tok(input logic [sct_pkg::KIND_BITS-1:0] k,
                                    input logic [sct_pkg::VAL_BITS-1:0] v,
                                    input logic [LEN_BITS-1:0] n,
                                    input logic [LINE_BITS-1:0] ln,
                                    input logic [COL_BITS-1:0] cl,
                                    input logic ovf);
        tok_t t;
        t.kind  = k;
        t.value = v;
        t.len   = n;
        t.line  = ln;
        t.col   = cl;
        t.ovf   = ovf || ln == LINE_MAX || cl == COL_MAX;
        t.last  = 1'b0;
        return t;
    endfunction

    assign in_stall = q_full;
    assign fire     = in_valid && !q_full;
    assign end_in   = is_end || ch == 8'h00;
    assign word_char = sct_pkg::is_alpha(ch) || sct_pkg::is_digit(ch) || ch == "_";

    // Decimal accumulate: value * 10 + digit, with room to detect saturation.
    assign val_x10 = ({4'b0, nval_reg} << 3) + ({4'b0, nval_reg} << 1)
                   + {63'b0, ch[3:0]};

    assign held_pair  = sct_pkg::pair_kind(held_reg, ch);
    assign tlen_short = tlen_reg <= LEN_EIGHT;
    assign kw = sct_pkg::word_kind(prefix_reg, tlen_reg[3:0], tlen_short);

    // Next state and the up to two tokens caused by this byte.
    always_comb
    begin
        mode_next   = mode_reg;
        held_next   = held_reg;
        prefix_next = prefix_reg;
        tlen_next   = tlen_reg;
        nval_next   = nval_reg;
        novf_next   = novf_reg;
        sline_next  = sline_reg;
        scol_next   = scol_reg;
        do_scan     = 1'b0;
        a_v         = 1'b0;
        b_v         = 1'b0;
        a_tok       = mk_tok(sct_pkg::K_EOF, '0, '0, line_reg, col_reg, 1'b0);
        b_tok       = mk_tok(sct_pkg::K_EOF, '0, '0, line_reg, col_reg, 1'b0);

        // A pending word, number or held character flushes into slot A.
        case (mode_reg)
            M_WORD:  a_tok = mk_tok(kw, '0, tlen_reg, sline_reg, scol_reg, novf_reg);
            M_NUM:   a_tok = mk_tok(sct_pkg::K_INTLIT, nval_reg, tlen_reg,
                                    sline_reg, scol_reg, novf_reg);
            M_HELD:  a_tok = mk_tok(sct_pkg::single_kind(held_reg), '0, LEN_ONE,
                                    sline_reg, scol_reg, 1'b0);
            default: a_tok = mk_tok(sct_pkg::K_EOF, '0, '0, line_reg, col_reg, 1'b0);
        endcase

        if (end_in) begin
            a_v = mode_reg == M_WORD || mode_reg == M_NUM || mode_reg == M_HELD;
            b_v = 1'b1;
            mode_next   = M_IDLE;
            held_next   = 8'h00;
            prefix_next = '0;
            tlen_next   = '0;
            nval_next   = '0;
            novf_next   = 1'b0;
            sline_next  = LINE_ONE;
            scol_next   = COL_ONE;
        end else begin
            case (mode_reg)
                M_WORD:
                begin
                    if (word_char) begin
                        for (int j = 0; j < 8; j++) begin
                            if (tlen_reg == LEN_BITS'(j)) begin
                                prefix_next[8*j +: 8] = ch;
                            end
                        end
                        if (tlen_reg == LEN_MAX) novf_next = 1'b1;
                        else tlen_next = tlen_reg + LEN_ONE;
                    end else begin
                        a_v     = 1'b1;
                        do_scan = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (sct_pkg::is_digit(ch)) begin
                        if (val_x10[sct_pkg::VAL_BITS+3:sct_pkg::VAL_BITS] != 4'b0) begin
                            nval_next = VAL_MAX;
                            novf_next = 1'b1;
                        end else begin
                            nval_next = val_x10[sct_pkg::VAL_BITS-1:0];
                        end
                        if (tlen_reg == LEN_MAX) novf_next = 1'b1;
                        else tlen_next = tlen_reg + LEN_ONE;
                    end else begin
                        a_v     = 1'b1;
                        do_scan = 1'b1;
                    end
                end
                M_HELD:
                begin
                    if (held_pair != sct_pkg::K_EOF) begin
                        a_v       = 1'b1;
                        a_tok     = mk_tok(held_pair, '0, LEN_TWO, sline_reg, scol_reg,
                                           1'b0);
                        mode_next = M_IDLE;
                    end else if (held_reg == "/" && ch == "/") begin
                        mode_next = M_LCOM;
                    end else if (held_reg == "/" && ch == "*") begin
                        mode_next = M_BCOM;
                    end else begin
                        a_v     = 1'b1;
                        do_scan = 1'b1;
                    end
                end
                M_LCOM:
                begin
                    if (ch == 8'h0a) mode_next = M_IDLE;
                end
                M_BCOM:
                begin
                    if (ch == "*") mode_next = M_BSTAR;
                end
                M_BSTAR:
                begin
                    if (ch == "/") mode_next = M_IDLE;
                    else if (ch != "*") mode_next = M_BCOM;
                end
                default:
                begin
                    do_scan = 1'b1;
                end
            endcase

            // Scan the byte from the idle state: skip white space, start a token or emit one.
            if (do_scan) begin
                mode_next = M_IDLE;
                if (sct_pkg::is_space(ch)) begin
                    mode_next = M_IDLE;
                end else if (sct_pkg::is_alpha(ch) || ch == "_" || sct_pkg::is_digit(ch)
                             || sct_pkg::is_hold(ch)) begin
                    sline_next  = line_reg;
                    scol_next   = col_reg;
                    tlen_next   = LEN_ONE;
                    novf_next   = 1'b0;
                    prefix_next = '0;
                    nval_next   = '0;
                    if (sct_pkg::is_digit(ch)) begin
                        nval_next = {59'b0, ch[3:0]};
                        mode_next = M_NUM;
                    end else if (sct_pkg::is_hold(ch)) begin
                        held_next = ch;
                        mode_next = M_HELD;
                    end else begin
                        prefix_next = {56'b0, ch};
                        mode_next   = M_WORD;
                    end
                end else begin
                    b_v   = 1'b1;
                    b_tok = mk_tok(sct_pkg::punct_kind(ch), '0, LEN_ONE,
                                   line_reg, col_reg, 1'b0);
                end
            end
        end

        a_tok.last = !b_v;
        b_tok.last = 1'b1;
    end

    // Position counters advance once per byte and saturate; a newline returns the column to 1.
    always_comb
    begin
        line_next = line_reg;
        col_next  = col_reg;
        if (end_in) begin
            line_next = LINE_ONE;
            col_next  = COL_ONE;
        end else if (ch == 8'h0a) begin
            if (line_reg != LINE_MAX) line_next = line_reg + LINE_ONE;
            col_next = COL_ONE;
        end else if (col_reg != COL_MAX) begin
            col_next = col_reg + COL_ONE;
        end
    end

    // Token slots toward the queue; valid only on an accepted beat.
    assign push.a_v = fire && a_v;
    assign push.b_v = fire && b_v;
    assign tok_a    = a_tok;
    assign tok_b    = b_tok;

    // Scanner state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= M_IDLE;
            held_reg   <= 8'h00;
            prefix_reg <= '0;
            tlen_reg   <= '0;
            nval_reg   <= '0;
            novf_reg   <= 1'b0;
            line_reg   <= LINE_ONE;
            col_reg    <= COL_ONE;
            sline_reg  <= LINE_ONE;
            scol_reg   <= COL_ONE;
        end else if (fire) begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            prefix_reg <= prefix_next;
            tlen_reg   <= tlen_next;
            nval_reg   <= nval_next;
            novf_reg   <= novf_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            sline_reg  <= sline_next;
            scol_reg   <= scol_next;
        end
    end

endmodule

[rtl/sct_back.sv]
module sct_back #(
    parameter int LINE_BITS = sct_pkg::LINE_BITS_DEF,
    parameter int COL_BITS  = sct_pkg::COL_BITS_DEF,
    parameter int LEN_BITS  = sct_pkg::LEN_BITS_DEF,
    parameter int TOK_W     = sct_pkg::KIND_BITS + sct_pkg::VAL_BITS + LEN_BITS
                              + LINE_BITS + COL_BITS + 2
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sct_pkg::push_ctl_t            push,
    input  logic [TOK_W-1:0]              tok_a,
    input  logic [TOK_W-1:0]              tok_b,
    output logic                          q_full,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sct_pkg::KIND_BITS-1:0] kind,
    output logic [sct_pkg::VAL_BITS-1:0]  value,
    output logic [LEN_BITS-1:0]           length,
    output logic [LINE_BITS-1:0]          line,
    output logic [COL_BITS-1:0]           column,
    output logic                          overflow,
    output logic                          last
);

    typedef struct packed {
        logic [sct_pkg::KIND_BITS-1:0] kind;
        logic [sct_pkg::VAL_BITS-1:0]  value;
        logic [LEN_BITS-1:0]           len;
        logic [LINE_BITS-1:0]          line;
        logic [COL_BITS-1:0]           col;
        logic                          ovf;
        logic                          last;
    } tok_t;

    localparam int PTR_BITS = $clog2(sct_pkg::Q_DEPTH);
    localparam int CNT_BITS = $clog2(sct_pkg::Q_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] CNT_ROOM = CNT_BITS'(sct_pkg::Q_DEPTH - 2);
    localparam logic [PTR_BITS-1:0] PTR_ONE  = PTR_BITS'(1);

    tok_t                q_reg [sct_pkg::Q_DEPTH];
    logic [PTR_BITS-1:0] wp_reg, wp_next;
    logic [PTR_BITS-1:0] rp_reg, rp_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                ov_reg;
    tok_t                out_reg;
    logic                load;
    logic                pop;
    logic [1:0]          push_n;

    // The scanner may hand over two tokens per beat, so keep room for two.
    assign q_full = cnt_reg > CNT_ROOM;

    assign load   = !ov_reg || !out_stall;
    assign pop    = load && cnt_reg != '0;
    assign push_n = {1'b0, push.a_v} + {1'b0, push.b_v};

    assign wp_next  = wp_reg + PTR_BITS'(push_n);
    assign rp_next  = pop ? rp_reg + PTR_ONE : rp_reg;
    assign cnt_next = cnt_reg + CNT_BITS'(push_n) - CNT_BITS'(pop);

    // Queue storage, filled in order of the two slots.
    always_ff @(posedge clk)
    begin
        if (push.a_v) begin
            q_reg[wp_reg] <= tok_t'(tok_a);
            if (push.b_v) q_reg[wp_reg + PTR_ONE] <= tok_t'(tok_b);
        end else if (push.b_v) begin
            q_reg[wp_reg] <= tok_t'(tok_b);
        end
    end

    // Queue pointers and output beat valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
            if (load) ov_reg <= cnt_reg != '0;
        end
    end

    // Output register for the token on offer.
    always_ff @(posedge clk)
    begin
        if (pop) out_reg <= q_reg[rp_reg];
    end

    assign out_valid = ov_reg;
    assign kind      = out_reg.kind;
    assign value     = out_reg.value;
    assign length    = out_reg.len;
    assign line      = out_reg.line;
    assign column    = out_reg.col;
    assign overflow  = out_reg.ovf;
    assign last      = out_reg.last;

endmodule
